FILE: src/sqt_pkg.sv
// Shared types and constants for the sorted timer queue.
// Used by sqt_divider and sorted_timer_queue; depends on nothing.
package sqt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int RMCNT_W     = $clog2(TIMER_SLOTS + 1);
    localparam int MAX_EXPIRE  = 16;
    localparam int EXPCNT_W    = $clog2(MAX_EXPIRE + 1);

    localparam int TIME_W      = 32;
    localparam int OWNER_W     = 8;
    localparam int TAG_W       = 16;
    localparam int SLOT_OUT_W  = 4;
    localparam int MSPT_W      = 10;
    localparam int DIV_CNT_W   = $clog2(TIME_W);

    localparam logic [MSPT_W-1:0] MSPT_RESET = MSPT_W'(10);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_MS_PER_TICK = 1'b0;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ADDED    = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_REMOVED  = 3'd2,
        KIND_EXPIRED  = 3'd3,
        KIND_NONE     = 3'd4,
        KIND_EARLIEST = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REMOVE,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SLOT_OUT_W-1:0]  slot;
        logic [OWNER_W-1:0]     owner;
        logic [TAG_W-1:0]       tag;
        logic                   handler;
        logic [TIME_W-1:0]      value;
        logic                   last;
    } result_t;

endpackage

FILE: src/sqt_divider.sv
// Radix-2 restoring divider: 32-bit dividend by 10-bit divisor, one bit per cycle.
// Depends on sqt_pkg. A zero divisor divides as one.
module sqt_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sqt_pkg::TIME_W-1:0]   dividend,
    input  logic [sqt_pkg::MSPT_W-1:0]   divisor,
    output logic                         done,
    output logic [sqt_pkg::TIME_W-1:0]   quotient
);
    import sqt_pkg::*;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MSPT_W-1:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]     quo_reg, quo_next;
    logic [MSPT_W-1:0]     dvs_reg, dvs_next;
    logic [MSPT_W:0]       trial;
    logic [MSPT_W:0]       diff;

    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            dvs_next = (divisor == '0) ? MSPT_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[MSPT_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[MSPT_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(TIME_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/sorted_timer_queue.sv
// Sorted timer queue: an add runs the divider and then fills a free slot; remove and query scan all 16 slots;
// a tick rescans the table after each expired timer it takes, up to 16 expired timers per tick.
// One request at a time; busy is high from accept until the final result is shown.
// Results are one-cycle strobes and cannot be stalled; last marks the final one.
// rst_n clears all timers, the tick and the add sequence at once; ms_per_tick resets to 10.
// Depends on sqt_pkg and sqt_divider.
module sorted_timer_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       mode,
    input  logic [sqt_pkg::TIME_W-1:0]       delay_ms,
    input  logic [sqt_pkg::OWNER_W-1:0]      owner,
    input  logic [sqt_pkg::TAG_W-1:0]        tag,
    input  logic                             has_handler,
    output logic                             result_valid,
    output logic [2:0]                       kind,
    output logic [sqt_pkg::SLOT_OUT_W-1:0]   slot,
    output logic [sqt_pkg::OWNER_W-1:0]      owner_out,
    output logic [sqt_pkg::TAG_W-1:0]        tag_out,
    output logic                             handler_out,
    output logic [sqt_pkg::TIME_W-1:0]       value,
    output logic                             last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sqt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sqt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sqt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import sqt_pkg::*;

    state_t                state_reg, state_next;
    logic [MSPT_W-1:0]     mspt_reg;
    logic                  accept;

    mode_t                 req_mode_reg;
    logic [OWNER_W-1:0]    req_owner_reg;
    logic [TAG_W-1:0]      req_tag_reg;
    logic                  req_hnd_reg;

    logic [TIME_W-1:0]     tick_reg, tick_next;
    logic [TIME_W-1:0]     seq_reg, seq_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;

    logic [TIME_W-1:0]     exp_mem   [TIMER_SLOTS];
    logic [OWNER_W-1:0]    owner_mem [TIMER_SLOTS];
    logic [TAG_W-1:0]      tag_mem   [TIMER_SLOTS];
    logic                  hnd_mem   [TIMER_SLOTS];
    logic [TIME_W-1:0]     order_mem [TIMER_SLOTS];
    logic                  tbl_we;

    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [RMCNT_W-1:0]    rm_cnt_reg, rm_cnt_next;
    logic [EXPCNT_W-1:0]   n_reg, n_next;

    logic                  best_found_reg, best_found_next;
    logic [SLOT_W-1:0]     best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]     best_exp_reg, best_exp_next;
    logic [TIME_W-1:0]     best_age_reg, best_age_next;
    logic [OWNER_W-1:0]    best_owner_reg, best_owner_next;
    logic [TAG_W-1:0]      best_tag_reg, best_tag_next;
    logic                  best_hnd_reg, best_hnd_next;

    logic                  pend_valid_reg, pend_valid_next;
    result_t               pend_reg, pend_next;

    logic                  res_valid_reg, res_valid_next;
    result_t               res_reg, res_next;

    logic                  div_start;
    logic                  div_done;
    logic [TIME_W-1:0]     div_quotient;
    logic [TIME_W-1:0]     add_exp;

    logic                  free_any;
    logic [SLOT_W-1:0]     free_idx;
    logic                  cur_valid;
    logic [TIME_W-1:0]     cur_exp;
    logic [TIME_W-1:0]     cur_age;
    logic                  take;
    logic                  due;
    logic                  rm_hit;
    logic                  idx_last;
    logic                  cfg_we;

    // APB register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2:2] == REG_MS_PER_TICK) ?
                    APB_DATA_W'(mspt_reg) : '0;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign div_start = accept && (mode_t'(mode) == MODE_ADD);
    assign add_exp   = tick_reg + div_quotient;

    sqt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (delay_ms),
        .divisor  (mspt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                free_idx = SLOT_W'(i);
        end
    end
    assign free_any = ~&valid_reg;

    assign idx_last  = (idx_reg == SLOT_W'(TIMER_SLOTS - 1));
    assign cur_valid = valid_reg[idx_reg];
    assign cur_exp   = exp_mem[idx_reg];
    assign cur_age   = seq_reg - order_mem[idx_reg];
    assign take      = cur_valid &&
                       (!best_found_reg || (cur_exp < best_exp_reg) ||
                        ((cur_exp == best_exp_reg) && (cur_age > best_age_reg)));
    assign due       = best_found_reg && (best_exp_reg <= tick_reg);
    assign rm_hit    = cur_valid && (owner_mem[idx_reg] == req_owner_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_t'(mode))
                        MODE_ADD:    state_next = ST_DIVIDE;
                        MODE_REMOVE: state_next = ST_REMOVE;
                        MODE_TICK:   state_next = ST_SCAN;
                        MODE_QUERY:  state_next = ST_SCAN;
                    endcase
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            ST_REMOVE:
            begin
                if (idx_last)
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (idx_last)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                priority if (req_mode_reg == MODE_QUERY)
                    state_next = ST_IDLE;
                else if (due)
                    state_next = (n_reg + 1'b1 == EXPCNT_W'(MAX_EXPIRE)) ?
                                 ST_FLUSH : ST_SCAN;
                else
                    state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        tick_next       = tick_reg;
        seq_next        = seq_reg;
        valid_next      = valid_reg;
        tbl_we          = 1'b0;
        idx_next        = idx_reg;
        rm_cnt_next     = rm_cnt_reg;
        n_next          = n_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_exp_next   = best_exp_reg;
        best_age_next   = best_age_reg;
        best_owner_next = best_owner_reg;
        best_tag_next   = best_tag_reg;
        best_hnd_next   = best_hnd_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        res_valid_next  = 1'b0;
        res_next        = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    rm_cnt_next     = '0;
                    n_next          = '0;
                    best_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    if (mode_t'(mode) == MODE_TICK)
                        tick_next = tick_reg + 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.last  = 1'b1;
                    if (free_any)
                    begin
                        tbl_we               = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        seq_next             = seq_reg + 1'b1;
                        res_next.kind        = KIND_ADDED;
                        res_next.slot        = SLOT_OUT_W'(free_idx);
                        res_next.value       = add_exp;
                    end
                    else
                    begin
                        res_next.kind = KIND_FULL;
                    end
                end
            end
            ST_REMOVE:
            begin
                if (rm_hit)
                begin
                    valid_next[idx_reg] = 1'b0;
                    rm_cnt_next         = rm_cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_last)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.kind  = KIND_REMOVED;
                    res_next.value = TIME_W'(rm_cnt_next);
                    res_next.last  = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = idx_reg;
                    best_exp_next   = cur_exp;
                    best_age_next   = cur_age;
                    best_owner_next = owner_mem[idx_reg];
                    best_tag_next   = tag_mem[idx_reg];
                    best_hnd_next   = hnd_mem[idx_reg];
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                idx_next = '0;
                priority if (req_mode_reg == MODE_QUERY)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.kind  = KIND_EARLIEST;
                    res_next.value = best_found_reg ? best_exp_reg : '1;
                    res_next.last  = 1'b1;
                end
                else if (due)
                begin
                    if (pend_valid_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = pend_reg;
                        res_next.last  = 1'b0;
                    end
                    pend_valid_next          = 1'b1;
                    pend_next.kind           = KIND_EXPIRED;
                    pend_next.slot           = SLOT_OUT_W'(best_idx_reg);
                    pend_next.owner          = best_owner_reg;
                    pend_next.tag            = best_tag_reg;
                    pend_next.handler        = best_hnd_reg;
                    pend_next.value          = best_exp_reg;
                    pend_next.last           = 1'b0;
                    valid_next[best_idx_reg] = 1'b0;
                    n_next                   = n_reg + 1'b1;
                    best_found_next          = 1'b0;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next = pend_reg;
                    end
                    else
                    begin
                        res_next      = '0;
                        res_next.kind = KIND_NONE;
                    end
                    res_next.last = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                res_valid_next = 1'b1;
                res_next       = pend_reg;
                res_next.last  = 1'b1;
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mspt_reg       <= MSPT_RESET;
            tick_reg       <= '0;
            seq_reg        <= '0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            rm_cnt_reg     <= '0;
            n_reg          <= '0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            seq_reg        <= seq_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            rm_cnt_reg     <= rm_cnt_next;
            n_reg          <= n_next;
            best_found_reg <= best_found_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we && (paddr[2:2] == REG_MS_PER_TICK))
                mspt_reg <= pwdata[MSPT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_mode_reg  <= mode_t'(mode);
            req_owner_reg <= owner;
            req_tag_reg   <= tag;
            req_hnd_reg   <= has_handler;
        end
        best_idx_reg   <= best_idx_next;
        best_exp_reg   <= best_exp_next;
        best_age_reg   <= best_age_next;
        best_owner_reg <= best_owner_next;
        best_tag_reg   <= best_tag_next;
        best_hnd_reg   <= best_hnd_next;
        pend_reg       <= pend_next;
        res_reg        <= res_next;
    end

    // timer table
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            exp_mem[free_idx]   <= add_exp;
            owner_mem[free_idx] <= req_owner_reg;
            tag_mem[free_idx]   <= req_tag_reg;
            hnd_mem[free_idx]   <= req_hnd_reg;
            order_mem[free_idx] <= seq_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign kind         = res_reg.kind;
    assign slot         = res_reg.slot;
    assign owner_out    = res_reg.owner;
    assign tag_out      = res_reg.tag;
    assign handler_out  = res_reg.handler;
    assign value        = res_reg.value;
    assign last         = res_reg.last;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> busy)
        else $error("non-final result while idle");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("final result while still busy");
`endif

endmodule
